// ===== sv/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// Sweep-and-prune pair emitter package
// Shared field widths and the payload types of the input and result channels.
// ----------------------------------------------------------------------------
package spe_pkg;

  // Width of a body identifier on both channels.
  localparam int unsigned IdWidth = 6;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // One interval endpoint taken from the sorted stream.
  typedef struct packed {
    logic [IdWidth-1:0] body_id;
    logic               is_start;
    logic               frame_start;
  } item_t;

  // One candidate pair sent out.
  typedef struct packed {
    logic [IdWidth-1:0] earlier_body;
    logic [IdWidth-1:0] later_body;
    logic               last_of_run;
  } pair_t;

endpackage

// ===== sv/spe_front.sv =====
// ----------------------------------------------------------------------------
// Sweep-and-prune front
// Keeps the open-body bitmap and posts one job for each start endpoint that
// finds other open bodies.
// ----------------------------------------------------------------------------
module spe_front #(
  parameter int unsigned MAX_BODIES = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  spe_pkg::item_t                           in_item_i,
  output logic                                     job_valid_o,
  input  logic                                     job_ready_i,
  output logic [spe_pkg::IdWidth+MAX_BODIES-1:0]   job_data_o
);
  import spe_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BODIES);

  logic [MAX_BODIES-1:0] open_q, open_d;
  logic [MAX_BODIES-1:0] base;
  logic [MAX_BODIES-1:0] self_bit;
  logic [MAX_BODIES-1:0] others;
  logic                  accept;
  logic                  in_range;

  // An endpoint is taken only when the queue can hold a job.
  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && job_ready_i;

  // Ids at or above the body count are ignored apart from the frame clear.
  assign in_range = ({1'b0, in_item_i.body_id} < (IdWidth+1)'(MAX_BODIES));

  // Classify the endpoint against the open set.
  always_comb begin
    base     = in_item_i.frame_start ? '0 : open_q;
    self_bit = '0;
    self_bit[in_item_i.body_id[IdxW-1:0]] = 1'b1;
    others   = base & ~self_bit;
    open_d   = open_q;
    if (accept) begin
      if (!in_range) begin
        open_d = base;
      end else if (in_item_i.is_start) begin
        open_d = base | self_bit;
      end else begin
        open_d = base & ~self_bit;
      end
    end
  end

  // A job is posted only when the run has at least one pair.
  assign job_valid_o = accept && in_range && in_item_i.is_start && (others != '0);
  assign job_data_o  = {in_item_i.body_id, others};

  // Open-body bitmap.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

// ===== sv/spe_queue.sv =====
// ----------------------------------------------------------------------------
// Sweep-and-prune job queue
// A short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module spe_queue #(
  parameter int unsigned WIDTH = 70,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import spe_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/spe_back.sv =====
// ----------------------------------------------------------------------------
// Sweep-and-prune back
// Walks one job's bitmap from the lowest id up; one pair per cycle unless stalled.
// ----------------------------------------------------------------------------
module spe_back #(
  parameter int unsigned MAX_BODIES = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     job_valid_i,
  output logic                                     job_ready_o,
  input  logic [spe_pkg::IdWidth+MAX_BODIES-1:0]   job_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output spe_pkg::pair_t                           out_pair_o
);
  import spe_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BODIES);

  logic [MAX_BODIES-1:0] work_map_q;
  logic [IdWidth-1:0]    work_id_q;
  logic                  work_valid_q;
  logic                  out_valid_q;
  pair_t                 out_q;

  logic [IdxW-1:0]       low_idx;
  logic [MAX_BODIES-1:0] low_bit;
  logic [MAX_BODIES-1:0] rest_map;
  logic                  last_now;
  logic                  advance;
  logic                  emit;
  logic                  load;

  // Lowest set bit of the remaining bitmap.
  always_comb begin
    low_idx = '0;
    for (int k = MAX_BODIES - 1; k >= 0; k--) begin
      if (work_map_q[k]) begin
        low_idx = IdxW'(k);
      end
    end
    low_bit          = '0;
    low_bit[low_idx] = 1'b1;
  end

  assign rest_map    = work_map_q & ~low_bit;
  assign last_now    = (rest_map == '0);
  assign advance     = !out_valid_q || out_ready_i;
  assign emit        = advance && work_valid_q;
  assign load        = job_valid_i && (!work_valid_q || (emit && last_now));
  assign job_ready_o = load;

  // Job being walked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
    end else if (load) begin
      work_valid_q <= 1'b1;
    end else if (emit && last_now) begin
      work_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_map_q <= job_data_i[MAX_BODIES-1:0];
      work_id_q  <= job_data_i[IdWidth+MAX_BODIES-1:MAX_BODIES];
    end else if (emit) begin
      work_map_q <= rest_map;
    end
  end

  // Output register decouples the walk from a stalled consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= work_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.earlier_body <= IdWidth'(low_idx);
      out_q.later_body   <= work_id_q;
      out_q.last_of_run  <= last_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pair_o  = out_q;

endmodule

// ===== sv/sweep_prune_pair_emitter_unit.sv =====
// Path: a start endpoint's first pair passes through the job queue, the back's
// work register and its output register before it reaches the output.
// Throughput: the back sends one pair per cycle unless the output stalls, one pair
// for each other open body; endpoints that owe no pair never reach the back.
// The front takes one endpoint per cycle while the two-entry job queue has room.
// Reset (asynchronous, active low) closes all bodies and empties the queue.
// ----------------------------------------------------------------------------
// Sweep-and-prune pair emitter
// One-axis broadphase: sorted endpoints in, candidate pairs out.
// ----------------------------------------------------------------------------
module sweep_prune_pair_emitter_unit #(
  parameter int unsigned MAX_BODIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  spe_pkg::item_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output spe_pkg::pair_t  out_pair_o
);
  import spe_pkg::*;

  localparam int unsigned JobW = IdWidth + MAX_BODIES;

  logic            push_valid, push_ready;
  logic [JobW-1:0] push_data;
  logic            pop_valid, pop_ready;
  logic [JobW-1:0] pop_data;

  // Front: open set and classification.
  spe_front #(
    .MAX_BODIES (MAX_BODIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_data_o  (push_data)
  );

  // Job queue between the two halves.
  spe_queue #(
    .WIDTH (JobW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: pair walk and output register.
  spe_back #(
    .MAX_BODIES (MAX_BODIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pair_o  (out_pair_o)
  );

endmodule
